@@ rtl/core/arpc_pkg.sv @@
`default_nettype none
package arpc_pkg;

  localparam int TABLE_ENTRIES = 16;

  localparam logic [1:0] ACT_LEARN  = 2'd0;
  localparam logic [1:0] ACT_LOOKUP = 2'd1;
  localparam logic [1:0] ACT_TICK   = 2'd2;
  localparam logic [1:0] ACT_CLEAR  = 2'd3;

  localparam logic [31:0] NEVER_OLD   = 32'hFFFF_FFFF;
  localparam logic [31:0] IP_BCAST    = 32'hFFFF_FFFF;
  localparam logic [47:0] MAC_BCAST   = 48'hFFFF_FFFF_FFFF;
  localparam logic [31:0] FLUSH_RESET = 32'd60000;

  localparam int PADDR_W = 5;
  localparam logic [PADDR_W-1:0] REG_OWN_IP  = 5'd0;
  localparam logic [PADDR_W-1:0] REG_OWN_MAC = 5'd8;
  localparam logic [PADDR_W-1:0] REG_FLUSH   = 5'd16;

  typedef struct packed {
    logic [1:0]  action;
    logic        sender_ok;
    logic        target_ok;
    logic        reply;
    logic [47:0] sender_mac;
    logic [31:0] sender_ip;
    logic [47:0] target_mac;
    logic [31:0] target_ip;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } qword_t;

  typedef struct packed {
    logic [31:0] ip;
    logic [47:0] mac;
    logic [31:0] stamp;
  } entry_t;

  typedef struct packed {
    logic        hit;
    logic [47:0] found_mac;
    logic        send_reply;
    logic        send_request;
    logic        flushed;
  } result_t;

  function automatic logic pair_ok(input logic [47:0] mac, input logic [31:0] ip);
    pair_ok = (mac != 48'd0) && (mac != MAC_BCAST) && (ip != 32'd0) && (ip != IP_BCAST);
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/arpc_if.sv @@
`default_nettype none
interface arpc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic        is_request;
  logic [47:0] sender_mac;
  logic [31:0] sender_ip;
  logic [47:0] target_mac;
  logic [31:0] target_ip;
  modport source (output valid, action, is_request, sender_mac, sender_ip, target_mac,
                  target_ip, input ready);
  modport sink (input valid, action, is_request, sender_mac, sender_ip, target_mac,
                target_ip, output ready);
endinterface

interface arpc_out_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic [47:0] found_mac;
  logic        send_reply;
  logic        send_request;
  logic        flushed;
  modport source (output valid, hit, found_mac, send_reply, send_request, flushed,
                  input ready);
  modport sink (input valid, hit, found_mac, send_reply, send_request, flushed,
                output ready);
endinterface
`default_nettype wire

@@ rtl/core/arpc_ram.sv @@
`default_nettype none
module arpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ rtl/core/arpc_front.sv @@
`default_nettype none
module arpc_front (
  input  wire logic        clk,
  input  wire logic        rst,
  arpc_in_if.sink          in_ch,
  input  wire logic [31:0] own_ip,
  output arpc_pkg::qword_t q,
  input  wire logic        q_pop,
  output logic [1:0]       q_count
);
  arpc_pkg::item_t slots [2];
  arpc_pkg::item_t cls;
  logic wr_ptr;
  logic rd_ptr;
  logic push;

  // classify: filter both pairs and decide the reply flag up front
  always_comb begin
    cls.action     = in_ch.action;
    cls.sender_ok  = arpc_pkg::pair_ok(in_ch.sender_mac, in_ch.sender_ip);
    cls.target_ok  = arpc_pkg::pair_ok(in_ch.target_mac, in_ch.target_ip);
    cls.reply      = in_ch.is_request && (in_ch.target_ip == own_ip);
    cls.sender_mac = in_ch.sender_mac;
    cls.sender_ip  = in_ch.sender_ip;
    cls.target_mac = in_ch.target_mac;
    cls.target_ip  = in_ch.target_ip;
  end

  assign in_ch.ready = (q_count != 2'd2);
  assign push        = in_ch.valid && in_ch.ready;
  assign q.valid     = (q_count != 2'd0);
  assign q.item      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= 1'b0;
      rd_ptr  <= 1'b0;
      q_count <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      q_count <= q_count + {1'b0, push} - {1'b0, q_pop};
    end
  end
endmodule
`default_nettype wire

@@ rtl/core/arpc_back.sv @@
`default_nettype none
module arpc_back #(
  parameter int TABLE_ENTRIES = arpc_pkg::TABLE_ENTRIES
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire arpc_pkg::qword_t q,
  output logic                  q_pop,
  input  wire logic [31:0]      own_ip,
  input  wire logic [47:0]      own_mac,
  input  wire logic [31:0]      flush_interval,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output arpc_pkg::result_t     res,
  output logic [TABLE_ENTRIES-1:0] valid_bits
);
  localparam int IW = $clog2(TABLE_ENTRIES);
  localparam int EW = $bits(arpc_pkg::entry_t);
  localparam logic [IW:0] LAST = (IW+1)'(TABLE_ENTRIES - 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_WRITE = 2'd2;

  logic [1:0]  state;
  arpc_pkg::item_t item;
  logic        pair_sel;
  logic [47:0] key_mac;
  logic [31:0] key_ip;
  logic [31:0] now_ticks;
  logic [31:0] next_flush;
  logic [IW:0] idx;
  logic        chk;
  logic [IW-1:0] chk_idx;

  logic        ipm, macm, free_f, hitf;
  logic [IW-1:0] free_i, best_i, slot;
  logic [31:0] best;
  logic [47:0] fmac;
  logic        ipm_next, macm_next, free_f_next, hitf_next;
  logic [IW-1:0] free_i_next, best_i_next;
  logic [31:0] best_next;
  logic [47:0] fmac_next;

  arpc_pkg::entry_t rd_ent, wr_ent;
  logic [EW-1:0] rdata;
  logic          we;
  logic [IW-1:0] waddr;
  logic [31:0]   now_inc;
  logic          v;
  logic          last_chk;

  assign rd_ent  = arpc_pkg::entry_t'(rdata);
  assign now_inc = now_ticks + 32'd1;
  assign v       = valid_bits[chk_idx];
  assign last_chk = chk && ({1'b0, chk_idx} == LAST);

  arpc_ram #(.WIDTH(EW), .DEPTH(TABLE_ENTRIES)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wr_ent),
    .raddr (idx[IW-1:0]),
    .rdata (rdata)
  );

  // fold the entry read last cycle into the search results
  always_comb begin
    ipm_next    = ipm;
    macm_next   = macm;
    free_f_next = free_f;
    free_i_next = free_i;
    best_next   = best;
    best_i_next = best_i;
    hitf_next   = hitf;
    fmac_next   = fmac;
    if (chk) begin
      if (v && rd_ent.ip == key_ip) begin
        ipm_next = 1'b1;
        if (!hitf) begin
          hitf_next = 1'b1;
          fmac_next = rd_ent.mac;
        end
      end
      if (v && rd_ent.mac == key_mac) begin
        macm_next = 1'b1;
      end
      if (!v && !free_f) begin
        free_f_next = 1'b1;
        free_i_next = chk_idx;
      end
      if (chk_idx == '0 || rd_ent.stamp <= best) begin
        best_next   = rd_ent.stamp;
        best_i_next = chk_idx;
      end
    end
  end

  // write port: flush installs ourselves at slot 0, insert fills the chosen slot
  always_comb begin
    we     = 1'b0;
    waddr  = slot;
    wr_ent = '{ip: key_ip, mac: key_mac, stamp: now_ticks};
    q_pop  = 1'b0;
    if (state == S_IDLE && q.valid && !out_valid) begin
      q_pop = 1'b1;
      if (q.item.action == arpc_pkg::ACT_CLEAR ||
          (q.item.action == arpc_pkg::ACT_TICK && now_inc >= next_flush)) begin
        we     = 1'b1;
        waddr  = '0;
        wr_ent = '{ip: own_ip, mac: own_mac, stamp: arpc_pkg::NEVER_OLD};
      end
    end else if (state == S_WRITE) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      valid_bits <= '0;
      now_ticks  <= '0;
      next_flush <= '0;
      chk        <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (q_pop) begin
            item <= q.item;
            res  <= '0;
            idx  <= '0;
            chk  <= 1'b0;
            ipm <= 1'b0; macm <= 1'b0; free_f <= 1'b0; hitf <= 1'b0;
            unique case (q.item.action)
              arpc_pkg::ACT_LEARN: begin
                res.send_reply <= q.item.reply;
                if (q.item.sender_ok) begin
                  pair_sel <= 1'b0;
                  key_mac  <= q.item.sender_mac;
                  key_ip   <= q.item.sender_ip;
                  state    <= S_SCAN;
                end else if (q.item.target_ok) begin
                  pair_sel <= 1'b1;
                  key_mac  <= q.item.target_mac;
                  key_ip   <= q.item.target_ip;
                  state    <= S_SCAN;
                end else begin
                  out_valid <= 1'b1;
                end
              end
              arpc_pkg::ACT_LOOKUP: begin
                key_mac <= q.item.target_mac;
                key_ip  <= q.item.target_ip;
                state   <= S_SCAN;
              end
              arpc_pkg::ACT_TICK: begin
                now_ticks <= now_inc;
                if (now_inc >= next_flush) begin
                  next_flush  <= now_inc + flush_interval;
                  valid_bits  <= TABLE_ENTRIES'(1);
                  res.flushed <= 1'b1;
                end
                out_valid <= 1'b1;
              end
              default: begin
                valid_bits  <= TABLE_ENTRIES'(1);
                res.flushed <= 1'b1;
                out_valid   <= 1'b1;
              end
            endcase
          end
        end
        S_SCAN: begin
          ipm <= ipm_next; macm <= macm_next; free_f <= free_f_next;
          free_i <= free_i_next; best <= best_next; best_i <= best_i_next;
          hitf <= hitf_next; fmac <= fmac_next;
          if (idx <= LAST) begin
            chk     <= 1'b1;
            chk_idx <= idx[IW-1:0];
            idx     <= idx + 1'b1;
          end else begin
            chk <= 1'b0;
          end
          if (last_chk) begin
            idx <= '0;
            chk <= 1'b0;
            if (item.action == arpc_pkg::ACT_LOOKUP) begin
              res.hit          <= hitf_next;
              res.found_mac    <= hitf_next ? fmac_next : 48'd0;
              res.send_request <= !hitf_next;
              out_valid        <= 1'b1;
              state            <= S_IDLE;
            end else if (!ipm_next && !macm_next) begin
              slot  <= free_f_next ? free_i_next : best_i_next;
              state <= S_WRITE;
            end else if (!pair_sel && item.target_ok) begin
              pair_sel <= 1'b1;
              key_mac  <= item.target_mac;
              key_ip   <= item.target_ip;
              ipm <= 1'b0; macm <= 1'b0; free_f <= 1'b0;
            end else begin
              out_valid <= 1'b1;
              state     <= S_IDLE;
            end
          end
        end
        S_WRITE: begin
          valid_bits[slot] <= 1'b1;
          idx <= '0;
          chk <= 1'b0;
          ipm <= 1'b0; macm <= 1'b0; free_f <= 1'b0;
          if (!pair_sel && item.target_ok) begin
            pair_sel <= 1'b1;
            key_mac  <= item.target_mac;
            key_ip   <= item.target_ip;
            state    <= S_SCAN;
          end else begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

@@ rtl/core/arp_cache_table.sv @@
// ARP cache table.
// Input channel in_ch carries one word per operation: learn (sender and
// target pairs of an ARP packet), lookup by target_ip, tick of the
// millisecond counter, or clear. Output channel out_ch returns exactly one
// result word per input word, in order.
// Configuration (own_ip, own_mac, flush_interval) is written over the APB
// port at byte addresses 0, 8 and 16; the user must write it only while the
// block is idle, which the block itself does not enforce.
// Flow: a front FIFO of two words takes input while the back works. The
// back scans the single-read-port table memory one entry per cycle: a
// lookup is one scan, a learn up to two; tick and clear need no scan.
// Reset clears the valid bits, the counters, the control state, own_ip and
// own_mac, and loads FLUSH_RESET into flush_interval; the table memory
// needs no clearing pass since valid bits gate every read.
// When the receiver stalls, the result word holds, the back stops, and the
// FIFO fills and then drops in_ch.ready.
`default_nettype none
module arp_cache_table #(
  parameter int TABLE_ENTRIES = arpc_pkg::TABLE_ENTRIES
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  arpc_in_if.sink                           in_ch,
  arpc_out_if.source                        out_ch,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [arpc_pkg::PADDR_W-1:0] paddr,
  input  wire logic [63:0]                  pwdata,
  output logic      [63:0]                  prdata,
  output logic                              pready
);
  logic [31:0] own_ip;
  logic [47:0] own_mac;
  logic [31:0] flush_interval;
  arpc_pkg::qword_t  q;
  logic              q_pop;
  logic [1:0]        q_count;
  arpc_pkg::result_t res;
  logic [TABLE_ENTRIES-1:0] valid_bits;

  // register file: write on the access cycle, pready always high
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_ip         <= '0;
      own_mac        <= '0;
      flush_interval <= arpc_pkg::FLUSH_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (paddr)
        arpc_pkg::REG_OWN_IP:  own_ip         <= pwdata[31:0];
        arpc_pkg::REG_OWN_MAC: own_mac        <= pwdata[47:0];
        arpc_pkg::REG_FLUSH:   flush_interval <= pwdata[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr)
      arpc_pkg::REG_OWN_IP:  prdata = {32'd0, own_ip};
      arpc_pkg::REG_OWN_MAC: prdata = {16'd0, own_mac};
      arpc_pkg::REG_FLUSH:   prdata = {32'd0, flush_interval};
      default:               prdata = '0;
    endcase
  end

  // front: accept and classify, hold up to two words
  arpc_front u_front (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .own_ip  (own_ip),
    .q       (q),
    .q_pop   (q_pop),
    .q_count (q_count)
  );

  // back: scan, insert, flush; drive the result register
  arpc_back #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_back (
    .clk            (clk),
    .rst            (rst),
    .q              (q),
    .q_pop          (q_pop),
    .own_ip         (own_ip),
    .own_mac        (own_mac),
    .flush_interval (flush_interval),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .res            (res),
    .valid_bits     (valid_bits)
  );

  assign out_ch.hit          = res.hit;
  assign out_ch.found_mac    = res.found_mac;
  assign out_ch.send_reply   = res.send_reply;
  assign out_ch.send_request = res.send_request;
  assign out_ch.flushed      = res.flushed;

  a_fifo_bound: assert property (@(posedge clk) disable iff (rst) q_count != 2'd3)
    else $error("front FIFO count out of range");
  a_flush_self: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.flushed |-> valid_bits[0])
    else $error("flush left slot 0 invalid");
  a_hit_xor_req: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> !(out_ch.hit && out_ch.send_request))
    else $error("hit and request both set");
  a_pop_when_free: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q.valid && !out_ch.valid)
    else $error("back took a word with a result pending");
endmodule
`default_nettype wire
